// ===== rtl/core/first_fit_heap_allocator_assert.svh =====
// Assertion macros for the first-fit heap allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// a implies b in the same cycle
`define FFHA_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("ffha assertion failed");
// a implies b in the next cycle
`define FFHA_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("ffha assertion failed");
`else
`define FFHA_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define FFHA_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/core/ffha_pkg.sv =====
// Shared types and constants of the first-fit heap allocator
package ffha_pkg;
    localparam int HEAP_W        = 13;
    localparam int REQ_BYTES_W   = 20;
    localparam int OFFSET_W      = 19;
    localparam int STATUS_W      = 2;
    localparam int NEED_W        = 14;
    localparam int GRANULE_BYTES = 128;
    localparam int GRAN_SHIFT    = 7;
    localparam int HEADER_BYTES  = 16;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_REFUSED = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    typedef enum logic [1:0] {RD_NONE, RD_G, RD_NX, RD_TGT} t_rd_sel;

    typedef enum logic [2:0] {
        WR_NONE, WR_CLR, WR_SPLIT_REM, WR_TAKE_G, WR_TAKE_TOP, WR_MARK_FREE,
        WR_KILL_NX, WR_MERGE_G
    } t_wr_sel;

    typedef enum logic [2:0] {
        RES_NONE, RES_GRANT_G, RES_GRANT_TOP, RES_REFUSE, RES_IGNORE, RES_DONE
    } t_res_sel;

    typedef struct packed {
        logic     cap;
        t_rd_sel  rd;
        t_wr_sel  wr;
        logic     latch;
        logic     g_adv;
        logic     clr_inc;
        t_res_sel res;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic zero_req;
        logic free_bad;
        logic g_lt_top;
        logic fit;
        logic split;
        logic bump_ok;
        logic tgt_ok;
        logic nx_ok;
        logic nx_free;
        logic clr_last;
        logic out_free;
    } t_stat;
endpackage

// ===== rtl/core/ffha_req_if.sv =====
// Request channel of the allocator
interface ffha_req_if;
    logic                             valid;
    logic                             ready;
    logic                             opcode;
    logic [ffha_pkg::REQ_BYTES_W-1:0] request_bytes;
    logic [ffha_pkg::OFFSET_W-1:0]    payload_offset;

    modport source (output valid, opcode, request_bytes, payload_offset, input ready);
    modport sink   (input valid, opcode, request_bytes, payload_offset, output ready);
endinterface

// ===== rtl/core/ffha_rsp_if.sv =====
// Result channel of the allocator
interface ffha_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [ffha_pkg::STATUS_W-1:0]    status;
    logic [ffha_pkg::OFFSET_W-1:0]    granted_offset;
    logic [ffha_pkg::REQ_BYTES_W-1:0] granted_bytes;

    modport source (output valid, status, granted_offset, granted_bytes, input ready);
    modport sink   (input valid, status, granted_offset, granted_bytes, output ready);
endinterface

// ===== rtl/core/ffha_dp.sv =====
// Allocator datapath: block table memory, walk pointer, heap top and result registers
module ffha_dp #(
    parameter int MAX_GRANULES = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ffha_pkg::t_cmd                   i_cmd,
    output ffha_pkg::t_stat                  o_stat,
    input  logic                             i_in_opcode,
    input  logic [ffha_pkg::REQ_BYTES_W-1:0] i_in_request_bytes,
    input  logic [ffha_pkg::OFFSET_W-1:0]    i_in_payload_offset,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [ffha_pkg::STATUS_W-1:0]    o_out_status,
    output logic [ffha_pkg::OFFSET_W-1:0]    o_out_offset,
    output logic [ffha_pkg::REQ_BYTES_W-1:0] o_out_bytes,
    input  logic                             i_cfg_we,
    input  logic [ffha_pkg::HEAP_W-1:0]      i_cfg_wdata,
    output logic [ffha_pkg::HEAP_W-1:0]      o_cfg_rdata
);
    import ffha_pkg::*;

    localparam int GW = $clog2(MAX_GRANULES);
    localparam int LW = $clog2(MAX_GRANULES + 1);

    typedef struct packed {
        logic          start;
        logic          free;
        logic [LW-1:0] len;
    } t_entry;

    t_entry r_mem [MAX_GRANULES];
    t_entry r_rdata;

    logic                   r_op;
    logic [NEED_W-1:0]      r_need;
    logic                   r_zero;
    logic                   r_bad;
    logic [GW-1:0]          r_gidx;
    logic [LW-1:0]          r_g;
    logic [LW-1:0]          r_cur_len;
    logic                   r_cur_free;
    logic [LW-1:0]          r_top;
    logic [GW-1:0]          r_clr;
    logic [HEAP_W-1:0]      r_heap;
    logic                   r_heap_dflt;
    t_status                r_pend_status;
    logic [OFFSET_W-1:0]    r_pend_off;
    logic [REQ_BYTES_W-1:0] r_pend_bytes;
    logic                   r_ovalid;
    t_status                r_ostatus;
    logic [OFFSET_W-1:0]    r_ooff;
    logic [REQ_BYTES_W-1:0] r_obytes;

    logic [31:0]   w_limit;
    logic [31:0]   w_base;
    logic [31:0]   w_nx;
    logic [LW-1:0] w_rd_len;
    logic [LW-1:0] w_merge_len;
    logic          w_re;
    logic [GW-1:0] w_rd_addr;
    logic          w_we;
    logic [GW-1:0] w_wr_addr;
    t_entry        w_wr_data;

    always_comb begin
        if (r_heap_dflt || 32'(r_heap) > 32'(MAX_GRANULES)) begin
            w_limit = 32'(MAX_GRANULES);
        end else begin
            w_limit = 32'(r_heap);
        end
        w_base      = 32'(i_in_payload_offset) - 32'(HEADER_BYTES);
        w_nx        = 32'(r_g) + 32'(r_cur_len);
        // a stored length of zero counts as one granule
        w_rd_len    = (r_rdata.len == '0) ? LW'(1) : r_rdata.len;
        w_merge_len = LW'(32'(r_cur_len) + 32'(w_rd_len));
    end

    always_comb begin
        w_re      = 1'b1;
        w_rd_addr = GW'(r_g);
        unique case (i_cmd.rd)
            RD_NONE: w_re = 1'b0;
            RD_G:    w_rd_addr = GW'(r_g);
            RD_NX:   w_rd_addr = GW'(w_nx);
            RD_TGT:  w_rd_addr = r_gidx;
            default: w_re = 1'b0;
        endcase
    end

    always_comb begin
        w_we      = 1'b1;
        w_wr_addr = GW'(r_g);
        w_wr_data = '0;
        unique case (i_cmd.wr)
            WR_NONE: w_we = 1'b0;
            WR_CLR:  w_wr_addr = r_clr;
            WR_SPLIT_REM: begin
                w_wr_addr = GW'(32'(r_g) + 32'(r_need));
                w_wr_data = '{start: 1'b1, free: 1'b1,
                              len: LW'(32'(r_cur_len) - 32'(r_need))};
            end
            WR_TAKE_G: begin
                w_wr_data = '{start: 1'b1, free: 1'b0, len: LW'(r_need)};
            end
            WR_TAKE_TOP: begin
                w_wr_addr = GW'(r_top);
                w_wr_data = '{start: 1'b1, free: 1'b0, len: LW'(r_need)};
            end
            WR_MARK_FREE: begin
                w_wr_addr = r_gidx;
                w_wr_data = '{start: 1'b1, free: 1'b1, len: r_rdata.len};
            end
            WR_KILL_NX: w_wr_addr = GW'(w_nx);
            WR_MERGE_G: begin
                w_wr_data = '{start: 1'b1, free: 1'b1, len: w_merge_len};
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // request capture and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op   <= i_in_opcode;
            r_zero <= (i_in_request_bytes == '0);
            r_need <= NEED_W'((32'(i_in_request_bytes) + 32'(HEADER_BYTES)
                      + 32'(GRANULE_BYTES - 1)) >> GRAN_SHIFT);
            r_bad  <= (32'(i_in_payload_offset) < 32'(HEADER_BYTES))
                      || (w_base[GRAN_SHIFT-1:0] != '0)
                      || ((w_base >> GRAN_SHIFT) >= 32'(r_top));
            r_gidx <= GW'(w_base >> GRAN_SHIFT);
            r_g    <= '0;
        end else if (i_cmd.g_adv) begin
            r_g <= LW'(w_nx);
        end
        if (i_cmd.latch) begin
            r_cur_free <= r_rdata.free;
            r_cur_len  <= w_rd_len;
        end else if (i_cmd.wr == WR_MERGE_G) begin
            r_cur_len <= w_merge_len;
        end
        unique case (i_cmd.res)
            RES_NONE: ;
            RES_GRANT_G: begin
                r_pend_status <= ST_DONE;
                r_pend_off    <= OFFSET_W'((32'(r_g) << GRAN_SHIFT) + 32'(HEADER_BYTES));
                r_pend_bytes  <= REQ_BYTES_W'((32'(r_need) << GRAN_SHIFT)
                                 - 32'(HEADER_BYTES));
            end
            RES_GRANT_TOP: begin
                r_pend_status <= ST_DONE;
                r_pend_off    <= OFFSET_W'((32'(r_top) << GRAN_SHIFT) + 32'(HEADER_BYTES));
                r_pend_bytes  <= REQ_BYTES_W'((32'(r_need) << GRAN_SHIFT)
                                 - 32'(HEADER_BYTES));
            end
            RES_REFUSE: begin
                r_pend_status <= ST_REFUSED;
                r_pend_off    <= '0;
                r_pend_bytes  <= '0;
            end
            RES_IGNORE: begin
                r_pend_status <= ST_IGNORED;
                r_pend_off    <= '0;
                r_pend_bytes  <= '0;
            end
            RES_DONE: begin
                r_pend_status <= ST_DONE;
                r_pend_off    <= '0;
                r_pend_bytes  <= '0;
            end
            default: ;
        endcase
        if (i_cmd.emit) begin
            r_ostatus <= r_pend_status;
            r_ooff    <= r_pend_off;
            r_obytes  <= r_pend_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= '0;
            r_clr       <= '0;
            r_heap      <= HEAP_W'(MAX_GRANULES);
            r_heap_dflt <= 1'b1;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cmd.wr == WR_TAKE_TOP) begin
                r_top <= LW'(32'(r_top) + 32'(r_need));
            end
            if (i_cmd.clr_inc) begin
                r_clr <= GW'(32'(r_clr) + 32'd1);
            end
            if (i_cfg_we) begin
                r_heap      <= i_cfg_wdata;
                r_heap_dflt <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.op       = r_op;
        o_stat.zero_req = r_zero;
        o_stat.free_bad = r_bad;
        o_stat.g_lt_top = 32'(r_g) < 32'(r_top);
        o_stat.fit      = r_cur_free && (32'(r_cur_len) >= 32'(r_need));
        o_stat.split    = 32'(r_cur_len) > 32'(r_need);
        o_stat.bump_ok  = (w_limit > 32'(r_top))
                          && ((w_limit - 32'(r_top)) >= 32'(r_need))
                          && (32'(r_top) < 32'(MAX_GRANULES));
        o_stat.tgt_ok   = r_rdata.start && !r_rdata.free;
        o_stat.nx_ok    = r_cur_free && (w_nx < 32'(r_top));
        o_stat.nx_free  = r_rdata.free;
        o_stat.clr_last = (32'(r_clr) == 32'(MAX_GRANULES - 1));
        o_stat.out_free = !r_ovalid || i_out_ready;
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_status = r_ostatus;
    assign o_out_offset = r_ooff;
    assign o_out_bytes  = r_obytes;
    assign o_cfg_rdata  = r_heap_dflt ? HEAP_W'(MAX_GRANULES) : r_heap;
endmodule

// ===== rtl/core/ffha_ctrl.sv =====
// Allocator controller: sequences table clearing, first-fit walk, bump and merge walk
module ffha_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ffha_pkg::t_stat i_stat,
    output ffha_pkg::t_cmd  o_cmd
);
    import ffha_pkg::*;

    typedef enum logic [15:0] {
        S_CLEAR   = 16'h0001,
        S_IDLE    = 16'h0002,
        S_START   = 16'h0004,
        S_A_RD    = 16'h0008,
        S_A_LAT   = 16'h0010,
        S_A_CHK   = 16'h0020,
        S_A_SPLIT = 16'h0040,
        S_A_TAKE  = 16'h0080,
        S_A_BUMP  = 16'h0100,
        S_F_CHK   = 16'h0200,
        S_M_RD    = 16'h0400,
        S_M_LAT   = 16'h0800,
        S_M_CHK   = 16'h1000,
        S_M_NX    = 16'h2000,
        S_M_MRG   = 16'h4000,
        S_RESP    = 16'h8000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.cap     = 1'b0;
        o_cmd.rd      = RD_NONE;
        o_cmd.wr      = WR_NONE;
        o_cmd.latch   = 1'b0;
        o_cmd.g_adv   = 1'b0;
        o_cmd.clr_inc = 1'b0;
        o_cmd.res     = RES_NONE;
        o_cmd.emit    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.wr      = WR_CLR;
                o_cmd.clr_inc = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_START;
                end
            end
            S_START: begin
                if (i_stat.op == OP_ALLOC) begin
                    if (i_stat.zero_req) begin
                        o_cmd.res = RES_REFUSE;
                        n_state   = S_RESP;
                    end else begin
                        n_state = S_A_RD;
                    end
                end else if (i_stat.free_bad) begin
                    o_cmd.res = RES_IGNORE;
                    n_state   = S_RESP;
                end else begin
                    o_cmd.rd = RD_TGT;
                    n_state  = S_F_CHK;
                end
            end
            S_A_RD: begin
                if (i_stat.g_lt_top) begin
                    o_cmd.rd = RD_G;
                    n_state  = S_A_LAT;
                end else begin
                    n_state = S_A_BUMP;
                end
            end
            S_A_LAT: begin
                o_cmd.latch = 1'b1;
                n_state     = S_A_CHK;
            end
            S_A_CHK: begin
                if (i_stat.fit) begin
                    n_state = i_stat.split ? S_A_SPLIT : S_A_TAKE;
                end else begin
                    o_cmd.g_adv = 1'b1;
                    n_state     = S_A_RD;
                end
            end
            S_A_SPLIT: begin
                o_cmd.wr = WR_SPLIT_REM;
                n_state  = S_A_TAKE;
            end
            S_A_TAKE: begin
                o_cmd.wr  = WR_TAKE_G;
                o_cmd.res = RES_GRANT_G;
                n_state   = S_RESP;
            end
            S_A_BUMP: begin
                if (i_stat.bump_ok) begin
                    o_cmd.wr  = WR_TAKE_TOP;
                    o_cmd.res = RES_GRANT_TOP;
                end else begin
                    o_cmd.res = RES_REFUSE;
                end
                n_state = S_RESP;
            end
            S_F_CHK: begin
                if (i_stat.tgt_ok) begin
                    o_cmd.wr = WR_MARK_FREE;
                    n_state  = S_M_RD;
                end else begin
                    o_cmd.res = RES_IGNORE;
                    n_state   = S_RESP;
                end
            end
            S_M_RD: begin
                if (i_stat.g_lt_top) begin
                    o_cmd.rd = RD_G;
                    n_state  = S_M_LAT;
                end else begin
                    o_cmd.res = RES_DONE;
                    n_state   = S_RESP;
                end
            end
            S_M_LAT: begin
                o_cmd.latch = 1'b1;
                n_state     = S_M_CHK;
            end
            S_M_CHK: begin
                if (i_stat.nx_ok) begin
                    o_cmd.rd = RD_NX;
                    n_state  = S_M_NX;
                end else begin
                    o_cmd.g_adv = 1'b1;
                    n_state     = S_M_RD;
                end
            end
            S_M_NX: begin
                // drop the right neighbour before the left block grows over it
                if (i_stat.nx_free) begin
                    o_cmd.wr = WR_KILL_NX;
                    n_state  = S_M_MRG;
                end else begin
                    o_cmd.g_adv = 1'b1;
                    n_state     = S_M_RD;
                end
            end
            S_M_MRG: begin
                o_cmd.wr = WR_MERGE_G;
                n_state  = S_M_CHK;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== rtl/core/first_fit_heap_allocator.sv =====
// First-fit heap allocator: one request at a time, walking the block table in address order.
// Allocate: walks the blocks until a free one fits, splitting off the remainder when it is
// larger, else bumps the heap top. Free: marks the block free, then walks the table merging
// each free block with a free right neighbour.
// After reset a clearing pass writes every entry of the block table before the first request.
// Results wait in an output register; one request is in flight at a time.
module first_fit_heap_allocator #(
    parameter int MAX_GRANULES = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ffha_req_if.sink                        i_req,
    ffha_rsp_if.source                      o_rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ffha_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ffha_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ffha_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import ffha_pkg::*;

    t_cmd              w_cmd;
    t_stat             w_stat;
    logic              w_cfg_we;
    logic [HEAP_W-1:0] w_cfg_rdata;

    // single register: writes land on it at address 0 only, reads return it at every address
    assign w_cfg_we = psel && penable && pwrite && pready && (paddr == '0);
    assign pready   = 1'b1;
    assign prdata   = APB_DATA_W'(w_cfg_rdata);

    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ffha_dp #(
        .MAX_GRANULES (MAX_GRANULES)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_in_opcode         (i_req.opcode),
        .i_in_request_bytes  (i_req.request_bytes),
        .i_in_payload_offset (i_req.payload_offset),
        .i_out_ready         (o_rsp.ready),
        .o_out_valid         (o_rsp.valid),
        .o_out_status        (o_rsp.status),
        .o_out_offset        (o_rsp.granted_offset),
        .o_out_bytes         (o_rsp.granted_bytes),
        .i_cfg_we            (w_cfg_we),
        .i_cfg_wdata         (pwdata[HEAP_W-1:0]),
        .o_cfg_rdata         (w_cfg_rdata)
    );

`include "first_fit_heap_allocator_assert.svh"

    `FFHA_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)
    `FFHA_ASSERT_IMPLY(a_port_shared, i_clk, i_rst_n, w_cmd.wr != WR_NONE, w_cmd.rd == RD_NONE)
    `FFHA_ASSERT_IMPLY(a_fail_zero, i_clk, i_rst_n, o_rsp.valid && o_rsp.status != ST_DONE, o_rsp.granted_offset == '0 && o_rsp.granted_bytes == '0)
    `FFHA_ASSERT_IMPLY(a_emit_free, i_clk, i_rst_n, w_cmd.emit, !o_rsp.valid || o_rsp.ready)
endmodule

// ===== tb/sv/first_fit_heap_allocator_tb.sv =====
// Self-checking testbench for the first-fit heap allocator
`timescale 1ns / 100ps

module first_fit_heap_allocator_tb;
    import ffha_pkg::*;

    localparam int TABLE_GRANULES = 4096;
    localparam int CYCLE_LIMIT    = 6000000;
    localparam int RANDOM_ITEMS   = 1950;
    localparam int MAX_LIVE       = 48;
    localparam logic [APB_ADDR_W-1:0] REG_HEAP_GRANULES = 2'd0;

    typedef struct packed {
        t_status               status;
        logic [OFFSET_W-1:0]   offset;
        logic [REQ_BYTES_W-1:0] nbytes;
    } t_grant;

    typedef struct {
        logic                   op;
        logic [REQ_BYTES_W-1:0] nbytes;
        logic [OFFSET_W-1:0]    offset;
        bit                     typed;
        t_grant                 want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    ffha_req_if req_if ();
    ffha_rsp_if rsp_if ();

    first_fit_heap_allocator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // allocator shadow state
    bit              blk_start [TABLE_GRANULES];
    bit              blk_free  [TABLE_GRANULES];
    int unsigned     blk_len   [TABLE_GRANULES];
    int unsigned     top_granule;
    int unsigned     heap_cfg;

    t_grant          pending_grants [$];
    logic [OFFSET_W-1:0] live_offsets [$];
    logic [OFFSET_W-1:0] last_freed;
    int unsigned     send_idle_pct;
    int unsigned     recv_idle_pct;
    int              errors;
    int              cycles;
    int              n_granted, n_refused, n_freed, n_ignored;

    function automatic int unsigned len_at(int unsigned g);
        return blk_len[g] == 0 ? 1 : blk_len[g];
    endfunction

    function automatic t_grant grant_of(int unsigned g, int unsigned n);
        t_grant r;
        r.status = ST_DONE;
        r.offset = OFFSET_W'(g * GRANULE_BYTES + HEADER_BYTES);
        r.nbytes = REQ_BYTES_W'(n * GRANULE_BYTES - HEADER_BYTES);
        return r;
    endfunction

    function automatic t_grant allocate(longint unsigned want_bytes);
        int unsigned need;
        int unsigned g, l, lim, room;
        t_grant r;
        r = '{ST_REFUSED, '0, '0};
        if (want_bytes == 0) return r;
        need = 32'((want_bytes + HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES);
        g = 0;
        while (g < top_granule && g < TABLE_GRANULES) begin
            l = len_at(g);
            if (blk_free[g] && l >= need) begin
                if (l > need) begin
                    if (g + need < TABLE_GRANULES) begin
                        blk_start[g + need] = 1;
                        blk_free[g + need]  = 1;
                        blk_len[g + need]   = l - need;
                    end
                    blk_len[g] = need;
                    l = need;
                end
                blk_free[g] = 0;
                return grant_of(g, l);
            end
            g += l;
        end
        lim  = heap_cfg > TABLE_GRANULES ? TABLE_GRANULES : heap_cfg;
        room = lim > top_granule ? lim - top_granule : 0;
        if (room >= need && top_granule < TABLE_GRANULES) begin
            g = top_granule;
            blk_start[g] = 1;
            blk_free[g]  = 0;
            blk_len[g]   = need;
            top_granule += need;
            return grant_of(g, need);
        end
        return r;
    endfunction

    function automatic t_grant release_block(int unsigned off);
        int unsigned base, g, l, nx;
        t_grant r;
        r = '{ST_IGNORED, '0, '0};
        if (off < HEADER_BYTES) return r;
        base = off - HEADER_BYTES;
        if (base % GRANULE_BYTES != 0 || base / GRANULE_BYTES >= top_granule ||
            base / GRANULE_BYTES >= TABLE_GRANULES) return r;
        g = base / GRANULE_BYTES;
        if (!blk_start[g] || blk_free[g]) return r;
        blk_free[g] = 1;
        g = 0;
        // coalesce free runs in one pass
        while (g < top_granule && g < TABLE_GRANULES) begin
            l  = len_at(g);
            nx = g + l;
            if (blk_free[g] && nx < top_granule && nx < TABLE_GRANULES && blk_free[nx]) begin
                blk_len[g]    = l + len_at(nx);
                blk_start[nx] = 0;
                blk_free[nx]  = 0;
            end else begin
                g = nx;
            end
        end
        r.status = ST_DONE;
        return r;
    endfunction

    function automatic t_grant predict_grant(logic op, logic [REQ_BYTES_W-1:0] nb,
                                             logic [OFFSET_W-1:0] off);
        if (op == OP_ALLOC) return allocate(nb);
        return release_block(off);
    endfunction

    // cycle counter and watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_grants.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random back-pressure, compare against oldest expectation
    always @(negedge i_clk) begin
        rsp_if.ready <= (recv_idle_pct == 0) || ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_grant exp_g;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_grants.size() == 0) begin
                errors++;
                $display("%0t: unexpected result status=%0d offset=%0d bytes=%0d", $time,
                         rsp_if.status, rsp_if.granted_offset, rsp_if.granted_bytes);
            end else begin
                exp_g = pending_grants.pop_front();
                if (rsp_if.status !== exp_g.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_g.status, rsp_if.status);
                end
                if (rsp_if.granted_offset !== exp_g.offset) begin
                    errors++;
                    $display("%0t: granted_offset expected %0d actual %0d", $time,
                             exp_g.offset, rsp_if.granted_offset);
                end
                if (rsp_if.granted_bytes !== exp_g.nbytes) begin
                    errors++;
                    $display("%0t: granted_bytes expected %0d actual %0d", $time,
                             exp_g.nbytes, rsp_if.granted_bytes);
                end
            end
        end
    end

    task automatic write_heap_granules(input int unsigned value);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = REG_HEAP_GRANULES;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        heap_cfg = value & 32'h1FFF;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // drive one request; called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input logic op, input logic [REQ_BYTES_W-1:0] nb,
                                input logic [OFFSET_W-1:0] off, input bit typed,
                                input t_grant typed_grant);
        t_grant got;
        int idx;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid          = 1'b1;
        req_if.opcode         = op;
        req_if.request_bytes  = nb;
        req_if.payload_offset = off;
        do @(posedge i_clk); while (!req_if.ready);
        got = predict_grant(op, nb, off);
        pending_grants.push_back(typed ? typed_grant : got);
        if (op == OP_ALLOC) begin
            if (got.status == ST_DONE) begin
                live_offsets.push_back(got.offset);
                n_granted++;
            end else n_refused++;
        end else if (got.status == ST_DONE) begin
            n_freed++;
            last_freed = off;
            foreach (live_offsets[i]) if (live_offsets[i] == off) idx = i;
            live_offsets.delete(idx);
        end else n_ignored++;
        @(negedge i_clk);
        req_if.valid = 1'b0;
    endtask

    task automatic drain(input int settle);
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_item();
        int unsigned pick, sz;
        logic [REQ_BYTES_W-1:0] nb;
        logic [OFFSET_W-1:0] off;
        logic op;
        pick = $urandom_range(0, 99);
        nb   = REQ_BYTES_W'($urandom);
        off  = OFFSET_W'($urandom);
        if (live_offsets.size() >= MAX_LIVE) pick = 60;
        if (pick >= 50 && pick < 88 && live_offsets.size() == 0) pick = 0;
        if (pick < 50) begin
            op = OP_ALLOC;
            sz = $urandom_range(0, 99);
            if (sz < 85) nb = REQ_BYTES_W'($urandom_range(1, 600));
            else if (sz < 93) nb = REQ_BYTES_W'($urandom_range(0, 8191));
            else nb = REQ_BYTES_W'($urandom_range(0, 524288));
        end else if (pick < 88) begin
            op  = OP_FREE;
            off = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
        end else begin
            op = OP_FREE;
            case ($urandom_range(0, 2))
                0: off = last_freed;
                1: off = OFFSET_W'($urandom_range(0, 4095) * GRANULE_BYTES + HEADER_BYTES);
                default: ;
            endcase
        end
        send_request(op, nb, off, 1'b0, '{ST_DONE, '0, '0});
    endtask

    task automatic add_row(ref t_row rows[$], input logic op, input int unsigned nb,
                           input int unsigned off, input bit typed, input t_status st,
                           input int unsigned g_off, input int unsigned g_bytes);
        t_row r;
        r.op = op;
        r.nbytes = REQ_BYTES_W'(nb);
        r.offset = OFFSET_W'(off);
        r.typed = typed;
        r.want = '{st, OFFSET_W'(g_off), REQ_BYTES_W'(g_bytes)};
        rows.push_back(r);
    endtask

    initial begin
        t_row rows [$];
        int unsigned phase_cfg [3];
        int unsigned phase_send [3];
        int unsigned phase_recv [3];
        int unsigned per_phase;

        errors = 0;
        cycles = 0;
        n_granted = 0; n_refused = 0; n_freed = 0; n_ignored = 0;
        last_freed = '0;
        heap_cfg = TABLE_GRANULES;
        top_granule = 0;
        foreach (blk_start[g]) begin
            blk_start[g] = 0;
            blk_free[g]  = 0;
            blk_len[g]   = 0;
        end
        send_idle_pct = 22;
        recv_idle_pct = 48;
        req_if.valid = 1'b0;
        req_if.opcode = OP_ALLOC;
        req_if.request_bytes = '0;
        req_if.payload_offset = '0;
        rsp_if.ready = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed sequence from a fresh heap
        add_row(rows, OP_ALLOC, 0, 0, 1, ST_REFUSED, 0, 0);
        add_row(rows, OP_ALLOC, 1, 0, 1, ST_DONE, 16, 112);
        add_row(rows, OP_ALLOC, 112, 0, 1, ST_DONE, 144, 112);
        add_row(rows, OP_ALLOC, 113, 0, 1, ST_DONE, 272, 240);
        add_row(rows, OP_ALLOC, 524288, 0, 1, ST_REFUSED, 0, 0);
        add_row(rows, OP_FREE, 0, 0, 1, ST_IGNORED, 0, 0);
        add_row(rows, OP_FREE, 0, 17, 1, ST_IGNORED, 0, 0);
        add_row(rows, OP_FREE, 0, 16, 1, ST_DONE, 0, 0);
        add_row(rows, OP_FREE, 0, 16, 1, ST_IGNORED, 0, 0);
        add_row(rows, OP_FREE, 0, 144, 0, ST_DONE, 0, 0);
        add_row(rows, OP_FREE, 0, 12816, 1, ST_IGNORED, 0, 0);
        add_row(rows, OP_FREE, 1048575, 524287, 1, ST_IGNORED, 0, 0);
        add_row(rows, OP_ALLOC, 1, 0, 0, ST_DONE, 0, 0);
        add_row(rows, OP_ALLOC, 200, 0, 0, ST_DONE, 0, 0);
        add_row(rows, OP_FREE, 0, 272, 0, ST_DONE, 0, 0);
        add_row(rows, OP_ALLOC, 300, 0, 0, ST_DONE, 0, 0);
        add_row(rows, OP_FREE, 0, 528, 0, ST_DONE, 0, 0);
        add_row(rows, OP_ALLOC, 523504, 0, 0, ST_DONE, 0, 0);
        add_row(rows, OP_ALLOC, 1, 0, 0, ST_DONE, 0, 0);
        add_row(rows, OP_ALLOC, 1, 0, 0, ST_DONE, 0, 0);
        add_row(rows, OP_ALLOC, 1, 0, 1, ST_REFUSED, 0, 0);
        add_row(rows, OP_FREE, 0, 784, 0, ST_DONE, 0, 0);
        foreach (rows[i])
            send_request(rows[i].op, rows[i].nbytes, rows[i].offset, rows[i].typed,
                         rows[i].want);

        // heap end lowered to one granule, then above the table, then a random value
        phase_cfg[0]  = 1;
        phase_cfg[1]  = 8191;
        phase_cfg[2]  = $urandom_range(1, TABLE_GRANULES);
        phase_send[0] = 22; phase_recv[0] = 48;
        phase_send[1] = 48; phase_recv[1] = 22;
        phase_send[2] = 0;  phase_recv[2] = 0;
        per_phase = RANDOM_ITEMS / 3;
        for (int p = 0; p < 3; p++) begin
            drain(16);
            write_heap_granules(phase_cfg[p]);
            send_idle_pct = phase_send[p];
            recv_idle_pct = phase_recv[p];
            for (int n = 0; n < per_phase; n++) random_item();
        end

        drain(32);
        $display("Covered %0d grants, %0d refusals, %0d frees, %0d ignored frees",
                 n_granted, n_refused, n_freed, n_ignored);
        $display("over three heap-end settings and three back-pressure profiles");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ffha_pkg.sv
rtl/core/ffha_req_if.sv
rtl/core/ffha_rsp_if.sv
rtl/core/ffha_dp.sv
rtl/core/ffha_ctrl.sv
rtl/core/first_fit_heap_allocator.sv
tb/sv/first_fit_heap_allocator_tb.sv
